// ===== rtl/core/i128a_pkg.sv =====
`timescale 1ns / 1ps

package i128a_pkg;

  localparam int HALF_BITS = 64;
  localparam int WORD_BITS = 2 * HALF_BITS;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_NOT = 4'd7,
    OP_SHL = 4'd8,
    OP_SHR = 4'd9,
    OP_ROL = 4'd10,
    OP_ROR = 4'd11
  } op_e;

  typedef struct packed {
    logic [3:0]           op;
    logic [HALF_BITS-1:0] a_high;
    logic [HALF_BITS-1:0] a_low;
    logic [HALF_BITS-1:0] b_high;
    logic [HALF_BITS-1:0] b_low;
    logic [7:0]           shift_amount;
  } alu_req_t;

  typedef struct packed {
    logic [HALF_BITS-1:0] result_high;
    logic [HALF_BITS-1:0] result_low;
    logic                 divide_by_zero;
  } alu_res_t;

endpackage

// ===== rtl/core/int128_alu.sv =====
`timescale 1ns / 1ps

// 128-bit integer ALU with a start/busy request port and a one-cycle result
// strobe. A request is taken when start_i is high and busy_o is low; the
// result then appears on res_o for exactly one cycle with res_valid_o high
// and must be captured there, as the block cannot be held off. Add, sub,
// logic ops, shifts and rotates are computed in S_EXEC and the result strobe
// is registered from there. Multiply is shift-and-add, one multiplier bit per
// step; divide is restoring, one quotient bit a cycle, with S_NEGA and S_NEGB
// taking operand magnitudes first and S_DFIX fixing the sign; a zero divisor
// returns zero with divide_by_zero set, without iterating. Every iteration
// goes through one shared 128-bit adder/subtractor. A new request can be
// taken in the cycle the previous result is strobed.
module int128_alu import i128a_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  alu_req_t req_i,
  output logic     res_valid_o,
  output alu_res_t res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NEGA = 3'd3;
  localparam logic [2:0] S_NEGB = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DFIX = 3'd6;

  logic [2:0]       state_q, state_d;
  logic             valid_q, valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [3:0] op_q, op_d;
  logic [7:0] sh_q, sh_d;
  word_t      a_q, a_d;
  word_t      b_q, b_d;
  word_t      rem_q, rem_d;
  word_t      res_q, res_d;
  logic       dz_q, dz_d;
  logic       neg_q, neg_d;

  word_t add_x, add_y, add_sum, rem_shift;
  logic  add_sub, add_cout, take, last;

  i128a_addsub u_addsub (
    .x_i    (add_x),
    .y_i    (add_y),
    .sub_i  (add_sub),
    .sum_o  (add_sum),
    .cout_o (add_cout)
  );

  assign rem_shift = {rem_q[WORD_BITS-2:0], a_q[WORD_BITS-1]};
  assign take      = rem_q[WORD_BITS-1] | add_cout;
  assign last      = (cnt_q == CNT_W'(WORD_BITS - 1));

  always_comb begin
    unique case (state_q) inside
      S_MUL: begin
        add_x   = rem_q;
        add_y   = a_q;
        add_sub = 1'b0;
      end
      S_NEGA, S_DFIX: begin
        add_x   = '0;
        add_y   = a_q;
        add_sub = 1'b1;
      end
      S_NEGB: begin
        add_x   = '0;
        add_y   = b_q;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = rem_shift;
        add_y   = b_q;
        add_sub = 1'b1;
      end
      default: begin
        add_x   = a_q;
        add_y   = b_q;
        add_sub = (op_q == OP_SUB);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cnt_d   = cnt_q;
    op_d    = op_q;
    sh_d    = sh_q;
    a_d     = a_q;
    b_d     = b_q;
    rem_d   = rem_q;
    res_d   = res_q;
    dz_d    = dz_q;
    neg_d   = neg_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = req_i.op;
          sh_d    = req_i.shift_amount;
          a_d     = {req_i.a_high, req_i.a_low};
          b_d     = {req_i.b_high, req_i.b_low};
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        dz_d    = 1'b0;
        valid_d = 1'b1;
        state_d = S_IDLE;
        case (op_q) inside
          OP_ADD, OP_SUB: res_d = add_sum;
          OP_MUL: begin
            rem_d   = '0;
            cnt_d   = '0;
            valid_d = 1'b0;
            state_d = S_MUL;
          end
          OP_DIV: begin
            if (b_q == '0) begin
              res_d = '0;
              dz_d  = 1'b1;
            end else begin
              neg_d   = a_q[WORD_BITS-1] ^ b_q[WORD_BITS-1];
              valid_d = 1'b0;
              state_d = S_NEGA;
            end
          end
          OP_AND:  res_d = a_q & b_q;
          OP_OR:   res_d = a_q | b_q;
          OP_XOR:  res_d = a_q ^ b_q;
          OP_NOT:  res_d = ~a_q;
          OP_SHL:  res_d = (sh_q >= 8'(WORD_BITS)) ? '0 : (a_q << sh_q);
          OP_SHR:  res_d = (sh_q >= 8'(WORD_BITS)) ? '0 : (a_q >> sh_q);
          OP_ROL:  res_d = {a_q[WORD_BITS-2:0], a_q[WORD_BITS-1]};
          OP_ROR:  res_d = {a_q[0], a_q[WORD_BITS-1:1]};
          default: res_d = '0;
        endcase
      end
      S_MUL: begin
        if (b_q[0]) begin
          rem_d = add_sum;
        end
        a_d   = {a_q[WORD_BITS-2:0], 1'b0};
        b_d   = {1'b0, b_q[WORD_BITS-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          res_d   = b_q[0] ? add_sum : rem_q;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_NEGA: begin
        if (a_q[WORD_BITS-1]) begin
          a_d = add_sum;
        end
        state_d = S_NEGB;
      end
      S_NEGB: begin
        if (b_q[WORD_BITS-1]) begin
          b_d = add_sum;
        end
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = take ? add_sum : rem_shift;
        a_d   = {a_q[WORD_BITS-2:0], take};
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          state_d = S_DFIX;
        end
      end
      S_DFIX: begin
        res_d   = neg_q ? add_sum : a_q;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      dz_q    <= dz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    sh_q  <= sh_d;
    a_q   <= a_d;
    b_q   <= b_d;
    rem_q <= rem_d;
    res_q <= res_d;
    neg_q <= neg_d;
  end

  assign busy_o                = (state_q != S_IDLE);
  assign res_valid_o           = valid_q;
  assign res_o.result_high     = res_q[WORD_BITS-1:HALF_BITS];
  assign res_o.result_low      = res_q[HALF_BITS-1:0];
  assign res_o.divide_by_zero  = dz_q;

endmodule

// ===== rtl/core/i128a_addsub.sv =====
`timescale 1ns / 1ps

module i128a_addsub import i128a_pkg::*; (
  input  word_t x_i,
  input  word_t y_i,
  input  logic  sub_i,
  output word_t sum_o,
  output logic  cout_o
);

  word_t y_eff;

  assign y_eff = sub_i ? ~y_i : y_i;
  assign {cout_o, sum_o} = {1'b0, x_i} + {1'b0, y_eff} + {{WORD_BITS{1'b0}}, sub_i};

endmodule

// ===== rtl/core/i128a_checker.sv =====
`timescale 1ns / 1ps

module i128a_checker import i128a_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input alu_req_t req_i,
  input logic     res_valid_o,
  input alu_res_t res_o
);

  // accepted request keeps the block busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after request");

  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result strobed while busy");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o)
    else $error("busy dropped without a result");

  // zero divisor returns zero
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.divide_by_zero) |->
      (res_o.result_high == '0 && res_o.result_low == '0))
    else $error("divide by zero with non-zero result");

endmodule

bind int128_alu i128a_checker u_i128a_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import i128a_pkg::*;

class alu_scoreboard;
  alu_res_t pending_results[$];
  int       mismatches = 0;

  function alu_res_t compute_result(alu_req_t rq);
    word_t    a, b, r, ma, mb;
    logic     dz;
    alu_res_t res;
    a  = {rq.a_high, rq.a_low};
    b  = {rq.b_high, rq.b_low};
    r  = '0;
    dz = 1'b0;
    case (rq.op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == '0) begin
          dz = 1'b1;
        end else begin
          ma = a[WORD_BITS-1] ? -a : a;
          mb = b[WORD_BITS-1] ? -b : b;
          r  = ma / mb;
          if (a[WORD_BITS-1] != b[WORD_BITS-1]) r = -r;
        end
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_NOT: r = ~a;
      OP_SHL: r = (rq.shift_amount >= WORD_BITS) ? '0 : a << rq.shift_amount;
      OP_SHR: r = (rq.shift_amount >= WORD_BITS) ? '0 : a >> rq.shift_amount;
      OP_ROL: r = {a[WORD_BITS-2:0], a[WORD_BITS-1]};
      OP_ROR: r = {a[0], a[WORD_BITS-1:1]};
      default: r = '0;
    endcase
    res.result_high    = r[WORD_BITS-1:HALF_BITS];
    res.result_low     = r[HALF_BITS-1:0];
    res.divide_by_zero = dz;
    return res;
  endfunction

  function void note_request(alu_req_t rq);
    pending_results.push_back(compute_result(rq));
  endfunction

  task report_mismatch(string what, logic [HALF_BITS-1:0] got, logic [HALF_BITS-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task check_result(alu_res_t got);
    alu_res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request outstanding", got.result_low, '0);
    end else begin
      want = pending_results.pop_front();
      if (got.result_high !== want.result_high)
        report_mismatch("result_high", got.result_high, want.result_high);
      if (got.result_low !== want.result_low)
        report_mismatch("result_low", got.result_low, want.result_low);
      if (got.divide_by_zero !== want.divide_by_zero)
        report_mismatch("divide_by_zero", HALF_BITS'(got.divide_by_zero),
                        HALF_BITS'(want.divide_by_zero));
    end
  endtask

  task check_drained();
    if (pending_results.size() != 0)
      report_mismatch("results never returned", HALF_BITS'(pending_results.size()), '0);
  endtask
endclass

module testbench;

  localparam logic [3:0] OP_UNDEF_LO = 4'd12;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam int         N_RANDOM    = 600;

  localparam word_t MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t ALL_ONES = '1;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  alu_req_t req_i;
  logic     res_valid_o;
  alu_res_t res_o;

  alu_scoreboard sb = new();
  bit            no_idling;

  int128_alu i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("FAIL int128_alu");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  function automatic alu_req_t make_request(logic [3:0] op, word_t a, word_t b, logic [7:0] sh);
    alu_req_t rq;
    rq.op           = op;
    rq.a_high       = a[WORD_BITS-1:HALF_BITS];
    rq.a_low        = a[HALF_BITS-1:0];
    rq.b_high       = b[WORD_BITS-1:HALF_BITS];
    rq.b_low        = b[HALF_BITS-1:0];
    rq.shift_amount = sh;
    return rq;
  endfunction

  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(0, 9))
      0: w = WORD_BITS'($urandom_range(0, 15));
      1: w = -word_t'($urandom_range(1, 15));
      2: w = '0;
      3: w = ALL_ONES;
      4: w = MOST_NEG;
      5: w = MOST_POS;
      6: w = {64'd0, $urandom(), $urandom()};
      default: w = {$urandom(), $urandom(), $urandom(), $urandom()};
    endcase
    return w;
  endfunction

  function automatic alu_req_t random_request();
    logic [3:0] op;
    word_t      b;
    logic [7:0] sh;
    if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
    else op = 4'($urandom_range(OP_ROR, OP_ADD));
    b = random_word();
    if (op == OP_DIV && $urandom_range(0, 7) == 0) b = '0;
    if ($urandom_range(0, 3) == 0) sh = 8'($urandom_range(255, WORD_BITS));
    else sh = 8'($urandom_range(WORD_BITS - 1, 0));
    return make_request(op, random_word(), b, sh);
  endfunction

  function automatic int gap_length();
    int g;
    if (no_idling) return 0;
    case ($urandom_range(0, 19))
      0, 1:          g = $urandom_range(20, 60);
      2, 3, 4, 5, 6: g = $urandom_range(1, 3);
      7, 8, 9:       g = $urandom_range(4, 9);
      default:       g = 0;
    endcase
    return g;
  endfunction

  // start_i stays high when the next request follows at once
  task send_request(alu_req_t rq, int gap);
    start_i <= 1'b1;
    req_i   <= rq;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(rq);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    alu_req_t directed[$];
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    req_i     = '0;
    no_idling = 1'b0;

    directed.push_back(make_request(OP_ADD, ALL_ONES, 128'd1, 8'd0));
    directed.push_back(make_request(OP_ADD, MOST_POS, MOST_POS, 8'd255));
    directed.push_back(make_request(OP_SUB, '0, 128'd1, 8'd0));
    directed.push_back(make_request(OP_SUB, MOST_NEG, 128'd1, 8'd3));
    directed.push_back(make_request(OP_MUL, ALL_ONES, ALL_ONES, 8'd0));
    directed.push_back(make_request(OP_MUL, MOST_NEG, -word_t'(3), 8'd0));
    directed.push_back(make_request(OP_MUL, {$urandom(), $urandom(), $urandom(), $urandom()},
                                    {$urandom(), $urandom(), $urandom(), $urandom()}, 8'd9));
    directed.push_back(make_request(OP_DIV, MOST_NEG, '0, 8'd0));
    directed.push_back(make_request(OP_DIV, 128'd5, '0, 8'd7));
    directed.push_back(make_request(OP_DIV, MOST_NEG, ALL_ONES, 8'd0));
    directed.push_back(make_request(OP_DIV, -word_t'(7), 128'd2, 8'd0));
    directed.push_back(make_request(OP_DIV, 128'd7, -word_t'(2), 8'd0));
    directed.push_back(make_request(OP_DIV, 128'd3, MOST_POS, 8'd0));
    directed.push_back(make_request(OP_AND, ALL_ONES, MOST_NEG, 8'd0));
    directed.push_back(make_request(OP_OR, MOST_POS, MOST_NEG, 8'd0));
    directed.push_back(make_request(OP_XOR, ALL_ONES, MOST_POS, 8'd0));
    directed.push_back(make_request(OP_NOT, MOST_NEG, ALL_ONES, 8'd200));
    directed.push_back(make_request(OP_SHL, ALL_ONES, ALL_ONES, 8'd64));
    directed.push_back(make_request(OP_SHL, 128'd1, '0, 8'd127));
    directed.push_back(make_request(OP_SHL, ALL_ONES, '0, 8'd128));
    directed.push_back(make_request(OP_SHR, ALL_ONES, '0, 8'd63));
    directed.push_back(make_request(OP_SHR, ALL_ONES, '0, 8'd255));
    directed.push_back(make_request(OP_ROL, MOST_NEG, ALL_ONES, 8'd5));
    directed.push_back(make_request(OP_ROR, 128'd1, ALL_ONES, 8'd5));
    directed.push_back(make_request(OP_UNDEF_LO, ALL_ONES, ALL_ONES, 8'd255));
    directed.push_back(make_request(OP_UNDEF_HI, ALL_ONES, '0, 8'd1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i], gap_length());

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) no_idling = ($urandom_range(0, 2) == 0);
      if (n == N_RANDOM / 2) begin
        start_i <= 1'b0;
        wait_drained();
      end
      send_request(random_request(), gap_length());
    end
    start_i <= 1'b0;

    wait_drained();
    repeat (140) @(posedge clk_i);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("PASS int128_alu");
    end else begin
      $display("FAIL int128_alu");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/i128a_pkg.sv
rtl/core/i128a_addsub.sv
rtl/core/int128_alu.sv
rtl/core/i128a_checker.sv
tb/testbench.sv
